>>> rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// No dependencies; imported by every module of the block.
package lfu_pkg;

   localparam int unsigned WordW = 32;
   localparam int unsigned CsrW  = 5;
   localparam logic [CsrW-1:0] CapReset = 5'd16;

   localparam logic OpGet = 1'b0;
   localparam logic OpPut = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic signed [WordW-1:0] lookup_key;
      logic signed [WordW-1:0] store_value;
   } req_word_type;

   typedef struct packed {
      logic                    found;
      logic signed [WordW-1:0] read_value;
   } rsp_word_type;

   // One stored entry: key, value, use count and last-use stamp.
   typedef struct packed {
      logic [WordW-1:0] key;
      logic [WordW-1:0] value;
      logic [WordW-1:0] count;
      logic [WordW-1:0] stamp;
   } entry_row_type;

   typedef struct packed {
      logic clear;
      logic live;
      logic entry_valid;
   } scan_ctrl_type;

   typedef struct packed {
      logic hit;
      logic vic_have;
      logic free_have;
   } scan_status_type;

endpackage

>>> rtl/core/lfu_entry_ram.sv
// Entry storage: one write port, one read port with registered data.
// Depends on lfu_pkg for the row type.
module lfu_entry_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  lfu_pkg::entry_row_type wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output lfu_pkg::entry_row_type rd_data
);
   import lfu_pkg::*;

   entry_row_type mem [DEPTH];
   entry_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lfu_scan_unit.sv
// Shared scan unit: takes one entry per cycle, tracks key match, LFU/LRU
// victim, lowest free slot and valid count. Depends on lfu_pkg.
module lfu_scan_unit #(
   parameter int unsigned IDX_W = 4,
   parameter int unsigned CNT_W = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lfu_pkg::scan_ctrl_type ctrl,
   input  logic [IDX_W-1:0]       idx,
   input  lfu_pkg::entry_row_type row,
   input  logic [31:0]            key,
   output lfu_pkg::scan_status_type status,
   output logic [IDX_W-1:0]       hit_idx,
   output logic [IDX_W-1:0]       vic_idx,
   output logic [IDX_W-1:0]       free_idx,
   output logic [CNT_W-1:0]       nvalid,
   output lfu_pkg::entry_row_type hit_row
);
   import lfu_pkg::*;

   scan_status_type  status_ff;
   logic [CNT_W-1:0] nvalid_ff;
   logic [IDX_W-1:0] hit_idx_ff, vic_idx_ff, free_idx_ff;
   logic [WordW-1:0] vic_count_ff, vic_stamp_ff;
   entry_row_type    hit_row_ff;
   logic             key_eq, older;
   logic             take_hit, take_vic, take_free;

   always_comb begin
      key_eq    = (row.key == key);
      // strictly smaller count, or equal count with an older stamp
      older     = (row.count < vic_count_ff) ||
                  ((row.count == vic_count_ff) && (row.stamp < vic_stamp_ff));
      take_hit  = ctrl.live && ctrl.entry_valid && !status_ff.hit && key_eq;
      take_vic  = ctrl.live && ctrl.entry_valid && (!status_ff.vic_have || older);
      take_free = ctrl.live && !ctrl.entry_valid && !status_ff.free_have;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         status_ff <= '0;
         nvalid_ff <= '0;
      end else begin
         if (take_hit) begin
            status_ff.hit <= 1'b1;
         end
         if (take_vic) begin
            status_ff.vic_have <= 1'b1;
         end
         if (take_free) begin
            status_ff.free_have <= 1'b1;
         end
         if (ctrl.live && ctrl.entry_valid) begin
            nvalid_ff <= nvalid_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_hit) begin
         hit_idx_ff <= idx;
         hit_row_ff <= row;
      end
      if (take_vic) begin
         vic_idx_ff   <= idx;
         vic_count_ff <= row.count;
         vic_stamp_ff <= row.stamp;
      end
      if (take_free) begin
         free_idx_ff <= idx;
      end
   end

   assign status   = status_ff;
   assign hit_idx  = hit_idx_ff;
   assign vic_idx  = vic_idx_ff;
   assign free_idx = free_idx_ff;
   assign nvalid   = nvalid_ff;
   assign hit_row  = hit_row_ff;

endmodule

>>> rtl/core/lfu_cache_table_unit.sv
// Top level of the LFU cache table: sequencer, valid bits, time counter.
// Depends on lfu_pkg, lfu_entry_ram and lfu_scan_unit.
//
// Key-value cache with least-frequently-used replacement, oldest stamp
// breaking ties. Each request word is a get or a put and yields exactly one
// response word. A request walks the entry memory one entry per cycle
// through its single read port over all MAX_ENTRIES slots, then passes a
// drain state and an update state, which waits for a free output register
// and registers the response; the next request is taken only in idle. With
// capacity zero the scan is skipped and the request goes straight to the
// update state. A finished response waits in an output register while the
// next request is accepted and scanned. Valid bits sit in flip-flops
// cleared by reset, so no clearing pass is needed. The capacity register
// resets to 16; the user must write it through the csr port only while the
// block is idle, and the block itself does not enforce this.
module lfu_cache_table_unit #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lfu_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lfu_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [lfu_pkg::CsrW-1:0] csr_data
);
   import lfu_pkg::*;

   localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CapW = (CntW > CsrW) ? CntW : CsrW;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);
   localparam logic [CapW-1:0] MaxCap  = CapW'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   state_type        state_ff;
   req_word_type     req_ff;
   logic             skip_ff;
   logic [CsrW-1:0]  cap_ff;
   logic [WordW-1:0] time_ff;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [IdxW-1:0]  scan_idx_ff, rd_idx_ff;
   logic             rd_live_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_data_ff, rsp_data_in;

   entry_row_type    rd_row, hit_row, wr_row;
   logic             wr_en;
   logic [IdxW-1:0]  wr_addr, ins_idx;
   scan_ctrl_type    scan_ctrl;
   scan_status_type  scan_status;
   logic [IdxW-1:0]  hit_idx, vic_idx, free_idx;
   logic [CntW-1:0]  nvalid;
   logic [CapW-1:0]  eff_cap;
   logic [WordW-1:0] stamp_next, count_next;
   logic             accept, out_free, commit, evict;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_UPDATE) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign eff_cap = (CapW'(cap_ff) > MaxCap) ? MaxCap : CapW'(cap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   always_comb begin
      scan_ctrl.clear       = accept;
      scan_ctrl.live        = rd_live_ff;
      scan_ctrl.entry_valid = valid_ff[rd_idx_ff];
   end

   lfu_entry_ram #(
      .DEPTH (MAX_ENTRIES),
      .ADDR_W(IdxW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_row),
      .rd_addr(scan_idx_ff),
      .rd_data(rd_row)
   );

   lfu_scan_unit #(
      .IDX_W(IdxW),
      .CNT_W(CntW)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (scan_ctrl),
      .idx     (rd_idx_ff),
      .row     (rd_row),
      .key     (req_ff.lookup_key),
      .status  (scan_status),
      .hit_idx (hit_idx),
      .vic_idx (vic_idx),
      .free_idx(free_idx),
      .nvalid  (nvalid),
      .hit_row (hit_row)
   );

   // Result of the scan: update the hit entry, or on a put miss insert, evicting when full.
   always_comb begin
      stamp_next  = (time_ff == '1) ? time_ff : time_ff + WordW'(1);
      count_next  = (hit_row.count == '1) ? hit_row.count : hit_row.count + WordW'(1);
      evict       = (CapW'(nvalid) >= eff_cap);
      valid_in    = valid_ff;
      wr_en       = 1'b0;
      wr_addr     = hit_idx;
      wr_row      = hit_row;
      rsp_data_in = '0;
      ins_idx     = free_idx;
      if (evict && !(scan_status.free_have && (free_idx < vic_idx))) begin
         ins_idx = vic_idx;
      end
      if (commit && !skip_ff) begin
         if (scan_status.hit) begin
            wr_en        = 1'b1;
            wr_row.count = count_next;
            wr_row.stamp = stamp_next;
            if (req_ff.opcode == OpPut) begin
               wr_row.value = req_ff.store_value;
            end else begin
               rsp_data_in.found      = 1'b1;
               rsp_data_in.read_value = hit_row.value;
            end
         end else if (req_ff.opcode == OpPut) begin
            wr_en        = 1'b1;
            wr_addr      = ins_idx;
            wr_row.key   = req_ff.lookup_key;
            wr_row.value = req_ff.store_value;
            wr_row.count = WordW'(1);
            wr_row.stamp = stamp_next;
            if (evict) begin
               valid_in[vic_idx] = 1'b0;
            end
            valid_in[ins_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         time_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (wr_en) begin
            time_ff <= stamp_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rd_idx_ff <= scan_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         skip_ff      <= 1'b0;
         scan_idx_ff  <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_live_ff <= (state_ff == ST_SCAN);
         if (rsp_valid_ff && rsp_ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               scan_idx_ff <= '0;
               if (accept) begin
                  skip_ff  <= (cap_ff == '0);
                  state_ff <= (cap_ff == '0) ? ST_UPDATE : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_idx_ff == LastIdx) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  scan_idx_ff <= scan_idx_ff + IdxW'(1);
               end
            end
            ST_DRAIN: begin
               // let the last entry land in the scan unit
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_data_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/lfu_checker.sv
// Port-level checks for the LFU cache table, bound to the top level.
// Depends on lfu_pkg and lfu_cache_table_unit.
module lfu_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input lfu_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input lfu_pkg::rsp_word_type rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [lfu_pkg::CsrW-1:0] csr_data
);
   import lfu_pkg::*;

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.read_value == '0)
      else $error("read_value nonzero without found");

   // an accepted request keeps the block busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind lfu_cache_table_unit lfu_checker u_lfu_checker (.*);
